@@ design/thsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thsd_pkg
// Shared types, constants and the CRC-8 byte update for the scratchpad decoder.
// ----------------------------------------------------------------------------
package thsd_pkg;

  // scratchpad framing
  localparam int unsigned FRAME_LEN = 9;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned TEMP_W    = 19;

  // reflected CRC-8 polynomial, initial value zero
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // decoded reading handed from the frame stage to the scaling stage
  typedef struct packed {
    logic [RAW_W-1:0] raw;            // two's complement, 1/16 degree
    logic             reading_valid;
    logic             crc_good;
    logic             sensor_missing;
  } frame_res_t;

  // one byte of CRC-8, lsb first, eight bit steps
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc;
    d = data;
    for (int b = 0; b < 8; b++) begin
      mix = c[0] ^ d[0];
      c   = c >> 1;
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

@@ design/thsd_frame.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thsd_frame
// Input register, byte count, running CRC and kept bytes; decodes the raw
// reading when the CRC byte arrives and holds it in a result register.
// ----------------------------------------------------------------------------
module thsd_frame (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic [7:0]            family_code_i,
  input  logic                  frame_start_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output thsd_pkg::frame_res_t  res_o
);

  localparam int unsigned NKEEP = 5;
  localparam int unsigned KW    = $clog2(NKEEP);

  // slots of the kept bytes
  localparam logic [KW-1:0] K_LSB  = KW'(0);
  localparam logic [KW-1:0] K_MSB  = KW'(1);
  localparam logic [KW-1:0] K_CFG  = KW'(2);
  localparam logic [KW-1:0] K_REM  = KW'(3);
  localparam logic [KW-1:0] K_PER  = KW'(4);

  // byte positions inside the scratchpad
  localparam logic [thsd_pkg::CNT_W-1:0] B_LSB   = thsd_pkg::CNT_W'(0);
  localparam logic [thsd_pkg::CNT_W-1:0] B_MSB   = thsd_pkg::CNT_W'(1);
  localparam logic [thsd_pkg::CNT_W-1:0] B_CFG   = thsd_pkg::CNT_W'(4);
  localparam logic [thsd_pkg::CNT_W-1:0] B_REM   = thsd_pkg::CNT_W'(6);
  localparam logic [thsd_pkg::CNT_W-1:0] B_PER   = thsd_pkg::CNT_W'(7);
  localparam logic [thsd_pkg::CNT_W-1:0] B_CRC   = thsd_pkg::CNT_W'(8);
  localparam logic [thsd_pkg::CNT_W-1:0] B_DONE  = thsd_pkg::CNT_W'(thsd_pkg::FRAME_LEN);

  localparam logic [7:0] FAM_NINE_BIT = 8'h10;
  localparam logic [7:0] NO_DEVICE    = 8'hFF;
  localparam logic [7:0] RES_MASK     = 8'h60;
  localparam logic [7:0] RES_9BIT     = 8'h00;
  localparam logic [7:0] RES_10BIT    = 8'h20;
  localparam logic [7:0] RES_11BIT    = 8'h40;
  localparam logic [7:0] PER_C_FULL   = 8'h10;
  localparam logic [15:0] FRAC_MASK   = 16'hFFF0;
  localparam logic [15:0] REM_BIAS    = 16'd12;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_data_q;
  logic [7:0] s1_family_q;
  logic       s1_start_q;

  // frame state
  logic [thsd_pkg::CNT_W-1:0] count_q, count_d;
  logic [7:0]                 crc_q, crc_d;
  logic [7:0]                 kept_q [NKEEP];
  logic [7:0]                 kept_d [NKEEP];

  // result register
  logic                 res_valid_q;
  thsd_pkg::frame_res_t res_q, res_d;

  logic                       res_free;
  logic                       s1_go;
  logic [thsd_pkg::CNT_W-1:0] idx;
  logic [7:0]                 crc_base;
  logic                       is_body;
  logic                       is_final;
  logic                       crc_ok;
  logic                       missing;
  logic [15:0]                raw_in;
  logic [15:0]                raw_dec;
  logic [7:0]                 res_cfg;

  // handshake chain
  assign res_free   = !res_valid_q || res_ready_i;
  assign s1_go      = s1_valid_q && res_free;
  assign in_ready_o = !s1_valid_q || res_free;

  // position of the byte in the input register
  assign idx      = s1_start_q ? '0 : count_q;
  assign crc_base = s1_start_q ? 8'h00 : crc_q;
  assign is_body  = idx < B_CRC;
  assign is_final = idx == B_CRC;

  // next state of count, crc and kept bytes
  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    kept_d  = kept_q;
    if (s1_go) begin
      if (s1_start_q) begin
        count_d = '0;
        crc_d   = 8'h00;
      end
      if (is_body) begin
        crc_d   = thsd_pkg::crc8_byte(crc_base, s1_data_q);
        count_d = idx + thsd_pkg::CNT_W'(1);
        unique case (idx)
          B_LSB:   kept_d[K_LSB] = s1_data_q;
          B_MSB:   kept_d[K_MSB] = s1_data_q;
          B_CFG:   kept_d[K_CFG] = s1_data_q;
          B_REM:   kept_d[K_REM] = s1_data_q;
          B_PER:   kept_d[K_PER] = s1_data_q;
          default: ;
        endcase
      end else if (is_final) begin
        count_d = B_DONE;
      end
    end
  end

  // flags of the finished frame
  assign crc_ok  = crc_base == s1_data_q;
  assign missing = kept_q[K_PER] == NO_DEVICE;
  assign raw_in  = {kept_q[K_MSB], kept_q[K_LSB]};
  assign res_cfg = kept_q[K_CFG] & RES_MASK;

  // raw reading in sixteenths of a degree
  always_comb begin
    raw_dec = raw_in;
    if (s1_family_q == FAM_NINE_BIT) begin
      raw_dec = raw_in << 3;
      if (kept_q[K_PER] == PER_C_FULL) begin
        raw_dec = (raw_dec & FRAC_MASK) + REM_BIAS - {8'h00, kept_q[K_REM]};
      end
    end else begin
      unique case (res_cfg)
        RES_9BIT:  raw_dec = raw_in & 16'hFFF8;
        RES_10BIT: raw_dec = raw_in & 16'hFFFC;
        RES_11BIT: raw_dec = raw_in & 16'hFFFE;
        default:   raw_dec = raw_in;
      endcase
    end
  end

  always_comb begin
    res_d.crc_good       = crc_ok;
    res_d.sensor_missing = missing;
    res_d.reading_valid  = crc_ok && !missing;
    res_d.raw            = (crc_ok && !missing) ? raw_dec : '0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      count_q     <= '0;
      crc_q       <= 8'h00;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (res_free) begin
        res_valid_q <= s1_go && is_final;
      end
      count_q <= count_d;
      crc_q   <= crc_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q   <= data_byte_i;
      s1_family_q <= family_code_i;
      s1_start_q  <= frame_start_i;
    end
    if (s1_go && is_final) begin
      res_q <= res_d;
    end
    kept_q <= kept_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ design/thsd_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thsd_scale
// Converts the raw reading to hundredths of a degree (times 100, divided by
// 16 toward zero) into the output register.
// ----------------------------------------------------------------------------
module thsd_scale (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   res_valid_i,
  output logic                                   res_ready_o,
  input  thsd_pkg::frame_res_t                   res_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [thsd_pkg::TEMP_W-1:0]     temp_centi_o,
  output logic                                   reading_valid_o,
  output logic                                   crc_good_o,
  output logic                                   sensor_missing_o
);

  localparam int unsigned PROD_W = thsd_pkg::RAW_W + 7;

  logic                              out_valid_q;
  logic signed [thsd_pkg::TEMP_W-1:0] temp_q, temp_d;
  logic                              rvalid_q;
  logic                              crc_good_q;
  logic                              missing_q;

  logic              out_free;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] biased;

  assign out_free    = !out_valid_q || out_ready_i;
  assign res_ready_o = out_free;

  // scale by 100, bias negatives so the shift truncates toward zero
  assign prod   = {{(PROD_W-thsd_pkg::RAW_W){res_i.raw[thsd_pkg::RAW_W-1]}}, res_i.raw}
                  * PROD_W'(100);
  assign biased = prod + (prod[PROD_W-1] ? PROD_W'(15) : PROD_W'(0));
  assign temp_d = biased[PROD_W-1:4];

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (res_valid_i && out_free) begin
      temp_q     <= temp_d;
      rvalid_q   <= res_i.reading_valid;
      crc_good_q <= res_i.crc_good;
      missing_q  <= res_i.sensor_missing;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign temp_centi_o     = temp_q;
  assign reading_valid_o  = rvalid_q;
  assign crc_good_o       = crc_good_q;
  assign sensor_missing_o = missing_q;

endmodule

@@ design/thermometer_scratchpad_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermometer_scratchpad_decoder
// Checks and decodes the nine-byte scratchpad of a 1-Wire thermometer into a
// temperature in hundredths of a degree with CRC and presence flags.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | input     | in_valid_i/in_ready_o | data_byte_i family_code_i
//          |           |                       | frame_start_i
//  out     | output    | out_valid_o/out_ready_i | temp_centi_o reading_valid_o
//          |           |                       | crc_good_o sensor_missing_o
//
//  One byte is taken per cycle unless an output stall fills the registers;
//  results move from the frame result register to the output register.
//  The frame stage updates the CRC combinationally, a whole byte at a time.
//  Reset clears the byte count and CRC, so the first frame needs no start mark.
//  A stalled output backs up through the result and input registers before
//  in_ready_o drops.
// ----------------------------------------------------------------------------
module thermometer_scratchpad_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         data_byte_i,
  input  logic [7:0]                         family_code_i,
  input  logic                               frame_start_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [thsd_pkg::TEMP_W-1:0] temp_centi_o,
  output logic                               reading_valid_o,
  output logic                               crc_good_o,
  output logic                               sensor_missing_o
);

  logic                 res_valid;
  logic                 res_ready;
  thsd_pkg::frame_res_t res;

  // byte tracking, CRC and raw decode
  thsd_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .family_code_i (family_code_i),
    .frame_start_i (frame_start_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // scaling to hundredths and output register
  thsd_scale u_scale (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .res_valid_i      (res_valid),
    .res_ready_o      (res_ready),
    .res_i            (res),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .temp_centi_o     (temp_centi_o),
    .reading_valid_o  (reading_valid_o),
    .crc_good_o       (crc_good_o),
    .sensor_missing_o (sensor_missing_o)
  );

endmodule

@@ design/thsd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thsd_checker
// Port-level checks of the scratchpad decoder, bound to the top level.
// ----------------------------------------------------------------------------
module thsd_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_o,
  input  logic                               out_valid_o,
  input  logic                               out_ready_i,
  input  logic signed [thsd_pkg::TEMP_W-1:0] temp_centi_o,
  input  logic                               reading_valid_o,
  input  logic                               crc_good_o,
  input  logic                               sensor_missing_o
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temp_centi_o)
      && $stable(reading_valid_o) && $stable(crc_good_o) && $stable(sensor_missing_o))
    else $error("output changed while stalled");

  // a valid reading needs a matching crc and a present sensor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reading_valid_o |-> crc_good_o && !sensor_missing_o)
    else $error("reading flagged valid with failing checks");

  // a failed reading carries zero temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reading_valid_o |-> temp_centi_o == '0)
    else $error("failed reading carries a temperature");

  // a rising result needs a byte transfer back through the pipeline registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o ##1 out_valid_o |-> $past(in_valid_i && in_ready_o, 3))
    else $error("result without a preceding input transfer");

endmodule

bind thermometer_scratchpad_decoder thsd_checker u_thsd_checker (.*);

@@ sim/thermometer_scratchpad_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermometer_scratchpad_decoder_tb
// Streams scratchpad frames through the decoder with random idling on both
// channels and checks every reading against a byte-level prediction of the
// frame counter, CRC-8 and temperature scaling.
// ----------------------------------------------------------------------------
module thermometer_scratchpad_decoder_tb;

  localparam int unsigned TEMP_BITS = thsd_pkg::TEMP_W;
  localparam int unsigned PAD_BYTES = thsd_pkg::FRAME_LEN;

  // scratchpad codes
  localparam logic [7:0] FAMILY_NINE_BIT = 8'h10;
  localparam logic [7:0] FAMILY_TWELVE   = 8'h28;
  localparam logic [7:0] FAMILY_OTHER    = 8'h22;
  localparam logic [7:0] COUNT_PER_DEG   = 8'h10;
  localparam logic [7:0] NO_DEVICE       = 8'hFF;
  localparam logic [7:0] RES_FIELD       = 8'h60;
  localparam logic [7:0] RES_9BIT        = 8'h00;
  localparam logic [7:0] RES_10BIT       = 8'h20;
  localparam logic [7:0] RES_11BIT       = 8'h40;
  localparam logic [7:0] CRC8_POLY       = 8'h8C;

  // run control
  localparam int unsigned BYTE_TARGET  = 950;
  localparam int unsigned HOLD_AT      = 700;
  localparam int unsigned HOLD_LEN     = 300;
  localparam int unsigned STUCK_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct {
    logic [7:0] data;
    logic [7:0] family;
    logic       start;
  } pad_byte_t;

  typedef struct {
    logic signed [TEMP_BITS-1:0] temp_centi;
    logic                        reading_valid;
    logic                        crc_good;
    logic                        sensor_missing;
  } reading_t;

  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready_o;
  logic [7:0]                  data_byte = 8'h00;
  logic [7:0]                  family_code = 8'h00;
  logic                        frame_start = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready = 1'b0;
  logic signed [TEMP_BITS-1:0] temp_centi_o;
  logic                        reading_valid_o;
  logic                        crc_good_o;
  logic                        sensor_missing_o;

  pad_byte_t scratchpad_bytes_q[$];
  reading_t  pending_readings_q[$];
  pad_byte_t offered_byte;
  reading_t  want;
  reading_t  predicted;
  bit        produced;

  // predicted decoder state
  logic [3:0] pad_count = '0;
  logic [7:0] pad_crc = '0;
  logic [7:0] pad_kept [0:4];

  logic [7:0] frame_buf [0:8];
  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned stuck_cycles = 0;

  thermometer_scratchpad_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte),
    .family_code_i   (family_code),
    .frame_start_i   (frame_start),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .temp_centi_o    (temp_centi_o),
    .reading_valid_o (reading_valid_o),
    .crc_good_o      (crc_good_o),
    .sensor_missing_o(sensor_missing_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // maxim crc-8, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = {1'b0, c[7:1]} ^ ((c[0] ^ data[i]) ? CRC8_POLY : 8'h00);
    end
    return c;
  endfunction

  // scale the kept bytes to hundredths of a degree
  function automatic logic signed [TEMP_BITS-1:0] scaled_temp(input logic [7:0] family);
    logic [15:0] raw;
    int          centi;
    raw = {pad_kept[1], pad_kept[0]};
    if (family == FAMILY_NINE_BIT) begin
      raw = raw << 3;
      if (pad_kept[4] == COUNT_PER_DEG) begin
        raw = (raw & 16'hFFF0) + 16'd12 - {8'h00, pad_kept[3]};
      end
    end else begin
      case (pad_kept[2] & RES_FIELD)
        RES_9BIT:  raw = raw & 16'hFFF8;
        RES_10BIT: raw = raw & 16'hFFFC;
        RES_11BIT: raw = raw & 16'hFFFE;
        default:   raw = raw;
      endcase
    end
    centi = $signed(raw);
    centi = (centi * 100) / 16;
    return centi[TEMP_BITS-1:0];
  endfunction

  // advance the predicted state by one transferred byte
  task automatic decode_byte(input pad_byte_t b, output bit has_reading, output reading_t r);
    has_reading     = 1'b0;
    r.temp_centi    = '0;
    r.reading_valid = 1'b0;
    r.crc_good      = 1'b0;
    r.sensor_missing = 1'b0;
    if (b.start) begin
      pad_count = '0;
      pad_crc   = '0;
    end
    if (pad_count < PAD_BYTES - 1) begin
      pad_crc = crc8_update(pad_crc, b.data);
      case (pad_count)
        4'd0:    pad_kept[0] = b.data;
        4'd1:    pad_kept[1] = b.data;
        4'd4:    pad_kept[2] = b.data;
        4'd6:    pad_kept[3] = b.data;
        4'd7:    pad_kept[4] = b.data;
        default: ;
      endcase
      pad_count = pad_count + 4'd1;
    end else if (pad_count == PAD_BYTES - 1) begin
      r.crc_good       = (pad_crc == b.data);
      r.sensor_missing = (pad_kept[4] == NO_DEVICE);
      r.reading_valid  = r.crc_good && !r.sensor_missing;
      if (r.reading_valid) begin
        r.temp_centi = scaled_temp(b.family);
      end
      pad_count   = PAD_BYTES;
      has_reading = 1'b1;
    end
  endtask

  task automatic push_byte(input logic [7:0] data, input logic [7:0] family, input logic start);
    pad_byte_t b;
    b.data   = data;
    b.family = family;
    b.start  = start;
    scratchpad_bytes_q.push_back(b);
  endtask

  // queue frame_buf as one frame, crc byte filled in and optionally corrupted
  task automatic push_frame(input logic [7:0] family, input logic with_start,
                            input logic [7:0] crc_flip);
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < PAD_BYTES - 1; i++) begin
      crc = crc8_update(crc, frame_buf[i]);
    end
    frame_buf[8] = crc ^ crc_flip;
    for (int i = 0; i < PAD_BYTES - 1; i++) begin
      push_byte(frame_buf[i], 8'($urandom_range(0, 255)), (i == 0) ? with_start : 1'b0);
    end
    push_byte(frame_buf[8], family, 1'b0);
  endtask

  // random frame contents with weighted corner values
  task automatic fill_random_frame(input logic [7:0] family);
    int unsigned pick;
    for (int i = 0; i < PAD_BYTES; i++) begin
      frame_buf[i] = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      frame_buf[0] = 8'h00;
      frame_buf[1] = 8'h80;
    end else if (pick == 1) begin
      frame_buf[0] = 8'hFF;
      frame_buf[1] = 8'h7F;
    end else if (pick == 2) begin
      frame_buf[0] = 8'h00;
      frame_buf[1] = 8'h00;
    end
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      frame_buf[7] = NO_DEVICE;
    end else if (pick < 9 || (family == FAMILY_NINE_BIT && pick < 14)) begin
      frame_buf[7] = COUNT_PER_DEG;
    end
  endtask

  // stimulus
  initial begin
    int unsigned kind;
    int unsigned n;
    logic [7:0]  family;
    logic [7:0]  flip;

    // first frame after reset with no start mark, most negative reading
    frame_buf[0] = 8'h00; frame_buf[1] = 8'h80; frame_buf[2] = 8'h4B;
    frame_buf[3] = 8'h46; frame_buf[4] = 8'h7F; frame_buf[5] = 8'hFF;
    frame_buf[6] = 8'h0C; frame_buf[7] = COUNT_PER_DEG;
    push_frame(FAMILY_TWELVE, 1'b0, 8'h00);
    // trailing byte with no start is dropped
    push_byte(8'hA5, 8'hFF, 1'b0);
    // aborted frame, then restart in mid-frame
    push_byte(8'h12, 8'h00, 1'b1);
    push_byte(8'h34, 8'h00, 1'b0);
    push_byte(8'h56, 8'h00, 1'b0);
    // nine-bit family with count-remain refinement
    frame_buf[0] = 8'hFF; frame_buf[1] = 8'h7F; frame_buf[2] = 8'h00;
    frame_buf[3] = 8'hFF; frame_buf[4] = 8'h00; frame_buf[5] = 8'h00;
    frame_buf[6] = 8'hFF; frame_buf[7] = COUNT_PER_DEG;
    push_frame(FAMILY_NINE_BIT, 1'b1, 8'h00);

    // random part: mostly well-formed frames
    while (scratchpad_bytes_q.size() < BYTE_TARGET) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        n = $urandom_range(0, 9);
        if (n < 4) family = FAMILY_NINE_BIT;
        else if (n < 7) family = FAMILY_TWELVE;
        else if (n < 8) family = FAMILY_OTHER;
        else family = 8'($urandom_range(0, 255));
        fill_random_frame(family);
        flip = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        push_frame(family, 1'b1, flip);
        if ($urandom_range(0, 6) == 0) begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) begin
            push_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
          end
        end
      end else if (kind < 17) begin
        // truncated frame
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          push_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), i == 0);
        end
      end else begin
        // noise with random start marks
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          push_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 2) == 0);
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample at the falling edge so the driver and monitor updates have settled
    while (scratchpad_bytes_q.size() != 0 || in_valid || pending_readings_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("thermometer_scratchpad_decoder test passed");
    end else begin
      $display("thermometer_scratchpad_decoder test failed");
    end
    $finish;
  end

  // sender: bursts and gaps, holds the byte until its transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        decode_byte(offered_byte, produced, predicted);
        if (produced) begin
          pending_readings_q.push_back(predicted);
        end
      end
      if (!(in_valid && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (scratchpad_bytes_q.size() > 0) begin
          offered_byte = scratchpad_bytes_q.pop_front();
          data_byte   <= offered_byte.data;
          family_code <= offered_byte.family;
          frame_start <= offered_byte.start;
          in_valid    <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cycle = rx_cycle + 1;
      if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN) begin
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 48) % 4)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((rx_cycle % 5) != 0);
        endcase
      end
    end
  end

  // compare each transferred reading with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_readings_q.size() == 0) begin
        $display("%0t: unexpected reading temp_centi %0d valid %0b", $time,
                 temp_centi_o, reading_valid_o);
        fail_count = fail_count + 1;
      end else begin
        want = pending_readings_q.pop_front();
        if (temp_centi_o !== want.temp_centi) begin
          $display("%0t: temp_centi expected %0d got %0d", $time,
                   want.temp_centi, temp_centi_o);
          fail_count = fail_count + 1;
        end
        if (reading_valid_o !== want.reading_valid) begin
          $display("%0t: reading_valid expected %0b got %0b", $time,
                   want.reading_valid, reading_valid_o);
          fail_count = fail_count + 1;
        end
        if (crc_good_o !== want.crc_good) begin
          $display("%0t: crc_good expected %0b got %0b", $time,
                   want.crc_good, crc_good_o);
          fail_count = fail_count + 1;
        end
        if (sensor_missing_o !== want.sensor_missing) begin
          $display("%0t: sensor_missing expected %0b got %0b", $time,
                   want.sensor_missing, sensor_missing_o);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles = stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
        $display("thermometer_scratchpad_decoder test failed");
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
design/thsd_pkg.sv
design/thsd_frame.sv
design/thsd_scale.sv
design/thermometer_scratchpad_decoder.sv
design/thsd_checker.sv
sim/thermometer_scratchpad_decoder_tb.sv
